[src/edd_pkg.sv]
package edd_pkg;

	localparam int MAX_WIDTH_DEF = 2048;

	// configuration port
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int WIDTH_W = 12;
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 12'd640;
	localparam logic REG_IMAGE_WIDTH = 1'b0;

	// pixel and result fields
	localparam int PIX_W = 8;
	localparam int LEVEL_W = 8;

	// error path: row entries, running sum and residual error share a width
	localparam int ERR_W = 9;
	localparam logic [ERR_W-1:0] SUM_MAX = 9'd511;
	localparam logic [LEVEL_W-1:0] CAP_MAX = 8'd255;
	localparam int RC_W = 7;	// 7/16 term
	localparam int DN_W = 7;	// 5/16 term
	localparam int DL_W = 6;	// 3/16 term
	localparam int DR_W = 5;	// 1/16 term

	// gray = floor((30r + 58g + 11b) / 100), division done as a reciprocal product
	localparam int LUMA_W = 15;
	localparam int PROD_W = 30;
	localparam int GRAY_SHIFT = 21;
	localparam logic [LUMA_W-1:0] GRAY_RECIP = 15'd20972;
	localparam logic [LUMA_W-1:0] COEF_R = 15'd30;
	localparam logic [LUMA_W-1:0] COEF_G = 15'd58;
	localparam logic [LUMA_W-1:0] COEF_B = 15'd11;

	typedef struct packed {
		logic last;
		logic has_left;
		logic first_row;
		logic frame_start;
		logic cur_ok;
		logic left_ok;
	} edd_ctl_t;

	function automatic logic [LUMA_W-1:0] luma(
		input logic [PIX_W-1:0] r,
		input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] b
	);
		luma = LUMA_W'(r) * COEF_R + LUMA_W'(g) * COEF_G + LUMA_W'(b) * COEF_B;
	endfunction

endpackage

[src/edd_ram.sv]
module edd_ram #(
	parameter int DEPTH = 1024,
	parameter int AW = 10,
	parameter int DW = 9
) (
	input  logic          clk,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// write-first: a read that meets a write to the same entry sees the new data
	always_ff @(posedge clk) begin
		if (re) begin
			if (we && (waddr == raddr)) begin
				rdata <= wdata;
			end else begin
				rdata <= mem[raddr];
			end
		end
	end

endmodule

[src/edd_seq.sv]
module edd_seq #(
	parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF,
	parameter int XW = ($clog2(MAX_WIDTH) < 1) ? 1 : $clog2(MAX_WIDTH),
	parameter int FW = $clog2(MAX_WIDTH + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [edd_pkg::WIDTH_W-1:0]  image_width,
	input  logic                         take,
	input  logic                         frame_start,
	input  logic                         adv,
	output logic [XW-1:0]                x_now,
	output logic [XW-1:0]                x_s1,
	output edd_pkg::edd_ctl_t            ctl_s1
);

	import edd_pkg::*;

	localparam int CW = (FW > WIDTH_W) ? FW : WIDTH_W;

	logic [CW-1:0] w_ext;
	logic [XW-1:0] wm1;
	logic [XW-1:0] col_q;
	logic [XW-1:0] col_eff;
	logic          first_row_q;
	logic          fr_eff;
	logic          last;
	logic          has_left;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] fill_nx;
	logic [FW-1:0] x1_s1;
	logic [FW-1:0] x_fw;

	// clamp the row width into 1..MAX_WIDTH and keep its last column
	always_comb begin
		w_ext = CW'(image_width);
		if (w_ext == '0) begin
			wm1 = '0;
		end else if (w_ext > CW'(MAX_WIDTH)) begin
			wm1 = XW'(MAX_WIDTH - 1);
		end else begin
			wm1 = XW'(w_ext - CW'(1));
		end
	end

	always_comb begin
		col_eff = frame_start ? '0 : col_q;
		x_now = (col_eff >= wm1) ? wm1 : col_eff;
		last = (x_now == wm1);
		has_left = (x_now != '0);
		fr_eff = frame_start | first_row_q;
		x_fw = FW'(x_now);
		// entries at or above the fill mark were never written since reset and read as zero
		x1_s1 = FW'(x_s1) + FW'(1);
		fill_nx = (adv && (x1_s1 > fill_q)) ? x1_s1 : fill_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			first_row_q <= 1'b1;
			fill_q <= '0;
		end else begin
			fill_q <= fill_nx;
			if (take) begin
				col_q <= last ? '0 : x_now + XW'(1);
				first_row_q <= last ? 1'b0 : fr_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_s1 <= x_now;
			ctl_s1.last <= last;
			ctl_s1.has_left <= has_left;
			ctl_s1.first_row <= fr_eff;
			ctl_s1.frame_start <= frame_start;
			ctl_s1.cur_ok <= (x_fw < fill_nx);
			ctl_s1.left_ok <= (x_fw <= fill_nx);
		end
	end

endmodule

[src/edd_diff.sv]
module edd_diff (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        take,
	input  logic [edd_pkg::PIX_W-1:0]   red,
	input  logic [edd_pkg::PIX_W-1:0]   green,
	input  logic [edd_pkg::PIX_W-1:0]   blue,
	input  logic                        adv,
	input  edd_pkg::edd_ctl_t           ctl_s1,
	input  logic [edd_pkg::ERR_W-1:0]   rd_cur,
	input  logic [edd_pkg::ERR_W-1:0]   rd_left,
	output logic [edd_pkg::LEVEL_W-1:0] level_nx,
	output logic [edd_pkg::ERR_W-1:0]   cur_val,
	output logic [edd_pkg::ERR_W-1:0]   left_val
);

	import edd_pkg::*;

	logic [PROD_W-1:0]  prod_s1;
	logic [RC_W-1:0]    rc_q;
	logic [RC_W-1:0]    rc;
	logic [DR_W-1:0]    drp_q;
	logic [DR_W-1:0]    drp;
	logic [PIX_W-1:0]   gray;
	logic [ERR_W-1:0]   below;
	logic [ERR_W-1:0]   left_old;
	logic [ERR_W:0]     raw;
	logic [ERR_W-1:0]   sum;
	logic [LEVEL_W-1:0] capped;
	logic [ERR_W-1:0]   err;
	logic [ERR_W+2:0]   ex;
	logic [ERR_W+2:0]   ex7;
	logic [ERR_W+2:0]   ex5;
	logic [ERR_W+2:0]   ex3;
	logic [RC_W-1:0]    e7;
	logic [DN_W-1:0]    e5;
	logic [DL_W-1:0]    e3;
	logic [DR_W-1:0]    e1;

	always_ff @(posedge clk) begin
		if (take) begin
			prod_s1 <= {{(PROD_W-LUMA_W){1'b0}}, luma(red, green, blue)}
				* {{(PROD_W-LUMA_W){1'b0}}, GRAY_RECIP};
		end
	end

	always_comb begin
		gray = prod_s1[GRAY_SHIFT +: PIX_W];
		rc = ctl_s1.frame_start ? '0 : rc_q;
		drp = ctl_s1.frame_start ? '0 : drp_q;
		below = (ctl_s1.first_row || !ctl_s1.cur_ok) ? '0 : rd_cur;
		left_old = ctl_s1.left_ok ? rd_left : '0;

		raw = (ERR_W+1)'(gray) + (ERR_W+1)'(rc) + (ERR_W+1)'(below);
		sum = (raw > (ERR_W+1)'(SUM_MAX)) ? SUM_MAX : raw[ERR_W-1:0];
		capped = (sum > ERR_W'(CAP_MAX)) ? CAP_MAX : sum[LEVEL_W-1:0];
		level_nx = {capped[LEVEL_W-1:4], 4'b0000};
		err = sum - ERR_W'(level_nx);

		ex = (ERR_W+3)'(err);
		ex7 = (ex << 3) - ex;
		ex5 = (ex << 2) + ex;
		ex3 = (ex << 1) + ex;
		e7 = RC_W'(ex7 >> 4);
		e5 = DN_W'(ex5 >> 4);
		e3 = DL_W'(ex3 >> 4);
		e1 = DR_W'(err >> 4);

		cur_val = ERR_W'(drp) + ERR_W'(e5);
		left_val = left_old + ERR_W'(e3);
	end

	// carry the right and down-right terms to the next pixel of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_q <= '0;
			drp_q <= '0;
		end else if (adv) begin
			rc_q <= ctl_s1.last ? '0 : e7;
			drp_q <= ctl_s1.last ? '0 : e1;
		end
	end

endmodule

[src/error_diffusion_dither_unit.sv]
// Error-diffusion dither to 16 gray levels: RGB pixels come in raster order,
// one 8-bit level (a multiple of 16) goes out per pixel. The unit accepts one pixel
// per clock while the output is not stalled; a pixel passes the stage-1 register,
// then the output register, which lets a new pixel in while the last level waits.
// The row of carried error sits in two single-port-read, single-port-write memories
// split by column parity, so each pixel reads and updates its own column and the
// one to its left in the same cycle, and the next pixel sees those writes through
// write-first bypass. Entries not yet written since reset read as zero through a
// fill mark, so no clearing pass is needed after reset. image_width (offset 0) must
// be written only while no pixel is in flight; the unit does not enforce this. 0 acts
// as 1 and values above MAX_WIDTH act as MAX_WIDTH. frame_start clears carried error.
module error_diffusion_dither_unit #(
	parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [edd_pkg::ADDR_W-1:0]  paddr,
	input  logic [edd_pkg::DATA_W-1:0]  pwdata,
	output logic [edd_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        pixel_valid,
	output logic                        pixel_ready,
	input  logic [edd_pkg::PIX_W-1:0]   red,
	input  logic [edd_pkg::PIX_W-1:0]   green,
	input  logic [edd_pkg::PIX_W-1:0]   blue,
	input  logic                        frame_start,
	output logic                        level_valid,
	input  logic                        level_ready,
	output logic [edd_pkg::LEVEL_W-1:0] level
);

	import edd_pkg::*;

	localparam int XW = ($clog2(MAX_WIDTH) < 1) ? 1 : $clog2(MAX_WIDTH);
	localparam int FW = $clog2(MAX_WIDTH + 1);
	localparam int DEPTH = (MAX_WIDTH + 1) / 2;
	localparam int AW = ($clog2(DEPTH) < 1) ? 1 : $clog2(DEPTH);

	logic [WIDTH_W-1:0] width_q;
	logic               reg_sel;
	logic               take;
	logic               adv;
	logic               valid_s1_q;
	logic               level_valid_q;
	logic [LEVEL_W-1:0] level_q;
	logic [LEVEL_W-1:0] level_nx;
	logic [XW-1:0]      x_now;
	logic [XW-1:0]      xm1_now;
	logic [XW-1:0]      x_s1;
	logic [XW-1:0]      xm1_s1;
	edd_ctl_t           ctl_s1;
	logic [AW-1:0]      raddr0;
	logic [AW-1:0]      raddr1;
	logic [AW-1:0]      waddr0;
	logic [AW-1:0]      waddr1;
	logic [ERR_W-1:0]   wdata0;
	logic [ERR_W-1:0]   wdata1;
	logic               we0;
	logic               we1;
	logic [ERR_W-1:0]   rdata0;
	logic [ERR_W-1:0]   rdata1;
	logic [ERR_W-1:0]   rd_cur;
	logic [ERR_W-1:0]   rd_left;
	logic [ERR_W-1:0]   cur_val;
	logic [ERR_W-1:0]   left_val;

	// configuration
	assign pready = 1'b1;
	assign reg_sel = (paddr[2] == REG_IMAGE_WIDTH);
	assign prdata = reg_sel ? DATA_W'(width_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			width_q <= pwdata[WIDTH_W-1:0];
		end
	end

	// handshake: stage 1 moves on whenever the output register is free or draining
	assign adv = valid_s1_q && (!level_valid_q || level_ready);
	assign pixel_ready = !valid_s1_q || adv;
	assign take = pixel_valid && pixel_ready;
	assign level_valid = level_valid_q;
	assign level = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			level_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1_q <= 1'b1;
			end else if (adv) begin
				valid_s1_q <= 1'b0;
			end
			if (adv) begin
				level_valid_q <= 1'b1;
			end else if (level_ready) begin
				level_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			level_q <= level_nx;
		end
	end

	edd_seq #(
		.MAX_WIDTH(MAX_WIDTH),
		.XW(XW),
		.FW(FW)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.image_width(width_q),
		.take(take),
		.frame_start(frame_start),
		.adv(adv),
		.x_now(x_now),
		.x_s1(x_s1),
		.ctl_s1(ctl_s1)
	);

	// even columns live in bank 0, odd columns in bank 1
	always_comb begin
		xm1_now = x_now - XW'(1);
		xm1_s1 = x_s1 - XW'(1);
		raddr0 = x_now[0] ? AW'(xm1_now >> 1) : AW'(x_now >> 1);
		raddr1 = x_now[0] ? AW'(x_now >> 1) : AW'(xm1_now >> 1);
		rd_cur = x_s1[0] ? rdata1 : rdata0;
		rd_left = x_s1[0] ? rdata0 : rdata1;
		if (x_s1[0]) begin
			waddr1 = AW'(x_s1 >> 1);
			wdata1 = cur_val;
			we1 = adv;
			waddr0 = AW'(xm1_s1 >> 1);
			wdata0 = left_val;
			we0 = adv && ctl_s1.has_left;
		end else begin
			waddr0 = AW'(x_s1 >> 1);
			wdata0 = cur_val;
			we0 = adv;
			waddr1 = AW'(xm1_s1 >> 1);
			wdata1 = left_val;
			we1 = adv && ctl_s1.has_left;
		end
	end

	edd_ram #(
		.DEPTH(DEPTH),
		.AW(AW),
		.DW(ERR_W)
	) u_bank0 (
		.clk(clk),
		.re(take),
		.raddr(raddr0),
		.rdata(rdata0),
		.we(we0),
		.waddr(waddr0),
		.wdata(wdata0)
	);

	edd_ram #(
		.DEPTH(DEPTH),
		.AW(AW),
		.DW(ERR_W)
	) u_bank1 (
		.clk(clk),
		.re(take),
		.raddr(raddr1),
		.rdata(rdata1),
		.we(we1),
		.waddr(waddr1),
		.wdata(wdata1)
	);

	edd_diff u_diff (
		.clk(clk),
		.arst_n(arst_n),
		.take(take),
		.red(red),
		.green(green),
		.blue(blue),
		.adv(adv),
		.ctl_s1(ctl_s1),
		.rd_cur(rd_cur),
		.rd_left(rd_left),
		.level_nx(level_nx),
		.cur_val(cur_val),
		.left_val(left_val)
	);

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1_q |-> (FW'(x_s1) < FW'(MAX_WIDTH)))
		else $error("column in flight beyond MAX_WIDTH");

	a_adv_loads: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> level_valid_q)
		else $error("advanced item did not reach output register");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> valid_s1_q)
		else $error("accepted item lost before stage 1");

	a_level_grid: assert property (@(posedge clk) disable iff (!arst_n)
		level_valid_q |-> (level_q[3:0] == 4'b0000))
		else $error("level off the 16-step grid");
`endif

endmodule

[dv/level_checker.sv]
module level_checker #(
	parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [edd_pkg::ADDR_W-1:0]  paddr,
	input  logic [edd_pkg::DATA_W-1:0]  pwdata,
	input  logic [edd_pkg::DATA_W-1:0]  prdata,
	input  logic                        pixel_valid,
	input  logic                        pixel_ready,
	input  logic [edd_pkg::PIX_W-1:0]   red,
	input  logic [edd_pkg::PIX_W-1:0]   green,
	input  logic [edd_pkg::PIX_W-1:0]   blue,
	input  logic                        frame_start,
	input  logic                        level_valid,
	input  logic                        level_ready,
	input  logic [edd_pkg::LEVEL_W-1:0] level,
	output int                          mismatch_count,
	output int                          pending_levels
);
	import edd_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam logic [ADDR_W-1:0] WIDTH_ADDR = ADDR_W'(4 * REG_IMAGE_WIDTH);

	logic [WIDTH_W-1:0] image_width;
	logic [ERR_W-1:0]   row_error [MAX_WIDTH];
	logic [ERR_W-1:0]   carry_right;
	logic [ERR_W-1:0]   carry_down_right;
	logic [COL_W-1:0]   column;
	logic               first_row;
	logic [LEVEL_W-1:0] expected_levels [$];

	function automatic void report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endfunction

	// Quantize one pixel and spread its error; updates the row state.
	function automatic logic [LEVEL_W-1:0] dither_pixel(
		input logic [PIX_W-1:0] r,
		input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] b,
		input logic             fs
	);
		int unsigned w, x, gray, sum, quant, err;
		w = image_width;
		if (w < 1)
			w = 1;
		if (w > MAX_WIDTH)
			w = MAX_WIDTH;
		if (fs) begin
			column = '0;
			carry_right = '0;
			carry_down_right = '0;
			first_row = 1'b1;
		end
		// a column past a shrunken width wraps the row here
		x = column;
		if (x >= w - 1)
			x = w - 1;
		gray = (300 * r + 580 * g + 110 * b) / 1000;
		sum = gray + carry_right;
		if (!first_row)
			sum += row_error[x];
		if (sum > SUM_MAX)
			sum = SUM_MAX;
		quant = ((sum > CAP_MAX) ? CAP_MAX : sum) & 'hF0;
		err = sum - quant;
		row_error[x] = ERR_W'(carry_down_right + ((err * 5) >> 4));
		if (x > 0)
			row_error[x - 1] = ERR_W'(row_error[x - 1] + ((err * 3) >> 4));
		if (x == w - 1) begin
			carry_right = '0;
			carry_down_right = '0;
			column = '0;
			first_row = 1'b0;
		end else begin
			carry_right = ERR_W'((err * 7) >> 4);
			carry_down_right = ERR_W'(err >> 4);
			column = COL_W'(x + 1);
		end
		return LEVEL_W'(quant);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width = WIDTH_RESET;
			for (int i = 0; i < MAX_WIDTH; i++)
				row_error[i] = '0;
			carry_right = '0;
			carry_down_right = '0;
			column = '0;
			first_row = 1'b1;
			expected_levels.delete();
			mismatch_count = 0;
			pending_levels = 0;
		end else begin
			if (psel && penable && pready && paddr == WIDTH_ADDR) begin
				if (pwrite)
					image_width = pwdata[WIDTH_W-1:0];
				else if (prdata[WIDTH_W-1:0] !== image_width)
					report_mismatch($sformatf("image_width read: expected %0d, got %0d",
						image_width, prdata[WIDTH_W-1:0]));
			end
			if (pixel_valid && pixel_ready)
				expected_levels.push_back(dither_pixel(red, green, blue, frame_start));
			if (level_valid && level_ready) begin
				if (expected_levels.size() == 0) begin
					report_mismatch($sformatf("level %0d with no pixel pending", level));
				end else begin
					if (level !== expected_levels[0])
						report_mismatch($sformatf("level: expected %0d, got %0d",
							expected_levels[0], level));
					void'(expected_levels.pop_front());
				end
			end
			pending_levels = expected_levels.size();
		end
	end

endmodule

[dv/testbench.sv]
module testbench;
	import edd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int LONG_STALL = 300;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 75;
	localparam logic [ADDR_W-1:0] WIDTH_ADDR = ADDR_W'(4 * REG_IMAGE_WIDTH);

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [DATA_W-1:0]  pwdata = '0;
	logic [DATA_W-1:0]  prdata;
	logic               pready;
	logic               pixel_valid = 1'b0;
	logic               pixel_ready;
	logic [PIX_W-1:0]   red = '0;
	logic [PIX_W-1:0]   green = '0;
	logic [PIX_W-1:0]   blue = '0;
	logic               frame_start = 1'b0;
	logic               level_valid;
	logic               level_ready = 1'b0;
	logic [LEVEL_W-1:0] level;
	int                 mismatch_count;
	int                 pending_levels;
	int                 cycle_count = 0;
	bit                 calm = 1'b0;
	int                 stall_asks = 0;

	error_diffusion_dither_unit u_dut (.*);

	level_checker u_level_checker (.*);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
	endfunction

	function automatic logic [PIX_W-1:0] channel(input int style);
		case (style)
			0: return PIX_W'($urandom_range(224, 255));	// bright: builds large error
			1: return PIX_W'($urandom_range(0, 31));
			default: return PIX_W'($urandom());
		endcase
	endfunction

	task automatic await_pready();
		bit ok;
		do begin
			@(negedge clk);
			ok = pready;
			@(posedge clk);
		end while (!ok);
	endtask

	task automatic push_pixel(
		input logic [PIX_W-1:0] r,
		input logic [PIX_W-1:0] g,
		input logic [PIX_W-1:0] b,
		input logic             fs
	);
		bit took;
		if (!calm && $urandom_range(0, 2) == 0) begin
			pixel_valid <= 1'b0;
			repeat (gap_len()) @(posedge clk);
		end
		red <= r;
		green <= g;
		blue <= b;
		frame_start <= fs;
		pixel_valid <= 1'b1;
		do begin
			@(negedge clk);
			took = pixel_ready;
			@(posedge clk);
		end while (!took);
	endtask

	// Drop valid and wait until every predicted level has come back.
	task automatic drain();
		pixel_valid <= 1'b0;
		do @(negedge clk); while (pending_levels != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_width(input int unsigned w);
		drain();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WIDTH_ADDR;
		pwdata <= DATA_W'(w);
		@(posedge clk);
		penable <= 1'b1;
		await_pready();
		// read back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		await_pready();
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	initial begin : receiver
		int idle_left;
		int stalls_seen;
		idle_left = 0;
		stalls_seen = 0;
		forever begin
			@(posedge clk);
			if (stall_asks != stalls_seen) begin
				stalls_seen = stall_asks;
				level_ready <= 1'b0;
				repeat (LONG_STALL) @(posedge clk);
			end
			if (idle_left > 0) begin
				idle_left--;
				level_ready <= 1'b0;
			end else begin
				level_ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					idle_left = gap_len();
			end
		end
	end

	initial begin : stimulus
		int unsigned w;
		int col_pos, rows_left, style;
		logic fs;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes and a mid-row frame start
		program_width(4);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		push_pixel(8'd255, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		push_pixel(8'd0, 8'd0, 8'd255, 1'b0);
		push_pixel(8'hAA, 8'h55, 8'hAA, 1'b0);
		push_pixel(8'h55, 8'hAA, 8'h55, 1'b1);

		// zero width acts as one
		program_width(0);
		repeat (3) push_pixel(8'd255, 8'd255, 8'd255, 1'b0);

		// width above the maximum clamps
		program_width(4095);
		push_pixel(8'd250, 8'd251, 8'd252, 1'b0);
		push_pixel(8'd7, 8'd128, 8'd200, 1'b0);

		// shrink mid-row: column past the new width wraps
		program_width(8);
		push_pixel(8'd240, 8'd240, 8'd240, 1'b1);
		repeat (3) push_pixel(8'd255, 8'd200, 8'd255, 1'b0);
		program_width(3);
		repeat (2) push_pixel(8'd100, 8'd150, 8'd50, 1'b0);

		// grow mid-frame: columns never written this frame
		program_width(2);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b1);
		repeat (2) push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		program_width(6);
		repeat (4) push_pixel(8'd245, 8'd245, 8'd245, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: w = 1;
				1: w = MAX_WIDTH_DEF;
				default: w = $urandom_range(2, 24);
			endcase
			calm = (p == 3);
			program_width(w);
			col_pos = 0;
			rows_left = 0;
			style = 2;
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (p == 4 && i == 10)
					stall_asks++;
				// frames of a few rows, now and then broken by a stray frame start
				fs = (i == 0) || (col_pos == 0 && rows_left == 0) ||
					($urandom_range(0, 39) == 0);
				if (fs) begin
					col_pos = 0;
					rows_left = $urandom_range(2, 6);
				end
				if (i % 8 == 0)
					style = $urandom_range(0, 3);
				push_pixel(channel(style), channel(style), channel(style), fs);
				col_pos++;
				if (col_pos >= w) begin
					col_pos = 0;
					rows_left--;
				end
			end
		end
		calm = 1'b0;

		drain();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[filelist.f]
src/edd_pkg.sv
src/edd_ram.sv
src/edd_seq.sv
src/edd_diff.sv
src/error_diffusion_dither_unit.sv
dv/level_checker.sv
dv/testbench.sv
